/* sv/crossing_gate_sequencer_assert.svh */
// Assertion macros for the crossing gate sequencer checker.
// No dependencies; included by the checker file.
`ifndef CROSSING_GATE_SEQUENCER_ASSERT_SVH
`define CROSSING_GATE_SEQUENCER_ASSERT_SVH

// same-cycle implication, off during reset
`define CGS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("crossing gate sequencer assertion failed");

// next-cycle implication, off during reset
`define CGS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("crossing gate sequencer assertion failed");

// next-cycle implication that also holds through reset
`define CGS_ASSERT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("crossing gate sequencer assertion failed");

`endif

/* sv/cgs_pkg.sv */
// Shared types and codes for the crossing gate sequencer.
// No dependencies.
package cgs_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned DELAY_W  = 16;
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned PHASE_W  = 4;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [DELAY_W-1:0] CLOSE_DELAY_RST = 16'd2000;
    localparam logic [DELAY_W-1:0] WHITE_DELAY_RST = 16'd1000;

    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WHITE_DELAY = 2'd1;

    localparam logic [CMD_W-1:0] TEST_KEEP   = 2'd0;
    localparam logic [CMD_W-1:0] TEST_STEADY = 2'd1;
    localparam logic [CMD_W-1:0] TEST_BLINK  = 2'd2;

    localparam logic [CMD_W-1:0] LAMP_NONE = 2'd0;
    localparam logic [CMD_W-1:0] LAMP_ON   = 2'd1;
    localparam logic [CMD_W-1:0] LAMP_FADE = 2'd2;

    localparam logic [CMD_W-1:0] BELL_NONE = 2'd0;
    localparam logic [CMD_W-1:0] BELL_RING = 2'd1;
    localparam logic [CMD_W-1:0] BELL_STOP = 2'd2;

    localparam logic [CMD_W-1:0] BAR_NONE  = 2'd0;
    localparam logic [CMD_W-1:0] BAR_CLOSE = 2'd1;
    localparam logic [CMD_W-1:0] BAR_OPEN  = 2'd2;

    localparam logic [CMD_W-1:0] TRK_CLOSE = 2'd1;
    localparam logic [CMD_W-1:0] TRK_OPEN  = 2'd2;

    localparam logic [CMD_W-1:0] BST_OPEN   = 2'd1;
    localparam logic [CMD_W-1:0] BST_CLOSED = 2'd2;

    localparam logic FEEDBACK_CLOSED = 1'b1;
    localparam logic FEEDBACK_OPEN   = 1'b0;

    typedef enum logic [PHASE_W-1:0] {
        PH_SETUP      = 4'd0,
        PH_IDLE       = 4'd1,
        PH_RED_START  = 4'd2,
        PH_WAIT_CLOSE = 4'd3,
        PH_CLOSING    = 4'd4,
        PH_BELL_OFF   = 4'd5,
        PH_CLOSED     = 4'd6,
        PH_OPENING    = 4'd7,
        PH_WAIT_WHITE = 4'd8
    } t_phase;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              key_event;
        logic [CMD_W-1:0]  track_command;
        logic              lamps_dark;
        logic [CMD_W-1:0]  barrier_one_status;
        logic [CMD_W-1:0]  barrier_two_status;
        logic              bell_stopped;
    } t_poll;

    typedef struct packed {
        logic [CMD_W-1:0]   test_lamp_cmd;
        logic [CMD_W-1:0]   white_lamp_cmd;
        logic [CMD_W-1:0]   red_lamp_cmd;
        logic [CMD_W-1:0]   bell_cmd;
        logic [CMD_W-1:0]   barrier_cmd;
        logic               feedback_write;
        logic               feedback_closed;
        logic [PHASE_W-1:0] phase_now;
    } t_result;

endpackage

/* sv/crossing_gate_sequencer.sv */
// Crossing gate sequencer: one result per poll, registered at accept; one poll per cycle
// while o_in_stall is low. The phase and deadline registers update at accept.
// A skid register holds one result while the output stalls; o_in_stall is that skid full.
// Synchronous active-low reset: phase setup, deadline zero, delays 2000 and 1000 ms,
// output and skid empty.
module crossing_gate_sequencer import cgs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DELAY_W-1:0]   i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [TIME_W-1:0]    i_now_ms,
    input  logic                 i_key_event,
    input  logic [CMD_W-1:0]     i_track_command,
    input  logic                 i_lamps_dark,
    input  logic [CMD_W-1:0]     i_barrier_one_status,
    input  logic [CMD_W-1:0]     i_barrier_two_status,
    input  logic                 i_bell_stopped,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [CMD_W-1:0]     o_test_lamp_cmd,
    output logic [CMD_W-1:0]     o_white_lamp_cmd,
    output logic [CMD_W-1:0]     o_red_lamp_cmd,
    output logic [CMD_W-1:0]     o_bell_cmd,
    output logic [CMD_W-1:0]     o_barrier_cmd,
    output logic                 o_feedback_write,
    output logic                 o_feedback_closed,
    output logic [PHASE_W-1:0]   o_phase_now
);

    logic [DELAY_W-1:0] r_close_delay_ms;
    logic [DELAY_W-1:0] r_white_delay_ms;
    t_phase             r_phase;
    logic [TIME_W-1:0]  r_deadline_ms;
    t_phase             n_phase;
    logic [TIME_W-1:0]  n_deadline_ms;

    t_poll              poll;
    t_result            result;
    t_result            r_out;
    t_result            r_skid;
    logic               r_out_valid;
    logic               r_skid_valid;
    logic               accept;
    logic               out_free;

    assign poll = '{now_ms:             i_now_ms,
                    key_event:          i_key_event,
                    track_command:      i_track_command,
                    lamps_dark:         i_lamps_dark,
                    barrier_one_status: i_barrier_one_status,
                    barrier_two_status: i_barrier_two_status,
                    bell_stopped:       i_bell_stopped};

    cgs_phase_logic u_phase (
        .i_phase          (r_phase),
        .i_deadline_ms    (r_deadline_ms),
        .i_close_delay_ms (r_close_delay_ms),
        .i_white_delay_ms (r_white_delay_ms),
        .i_poll           (poll),
        .o_phase          (n_phase),
        .o_deadline_ms    (n_deadline_ms),
        .o_result         (result)
    );

    assign o_in_stall = r_skid_valid;
    assign accept     = i_in_valid && !r_skid_valid;
    assign out_free   = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_close_delay_ms <= CLOSE_DELAY_RST;
            r_white_delay_ms <= WHITE_DELAY_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CLOSE_DELAY: r_close_delay_ms <= i_cfg_data;
                CFG_WHITE_DELAY: r_white_delay_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_SETUP;
            r_deadline_ms <= '0;
        end else if (accept) begin
            r_phase       <= n_phase;
            r_deadline_ms <= n_deadline_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || accept;
            r_skid_valid <= 1'b0;
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : result;
        end else if (accept) begin
            r_skid <= result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_test_lamp_cmd   = r_out.test_lamp_cmd;
    assign o_white_lamp_cmd  = r_out.white_lamp_cmd;
    assign o_red_lamp_cmd    = r_out.red_lamp_cmd;
    assign o_bell_cmd        = r_out.bell_cmd;
    assign o_barrier_cmd     = r_out.barrier_cmd;
    assign o_feedback_write  = r_out.feedback_write;
    assign o_feedback_closed = r_out.feedback_closed;
    assign o_phase_now       = r_out.phase_now;

endmodule

/* sv/cgs_phase_logic.sv */
// Next-phase, deadline and command decode for one poll.
// Depends on cgs_pkg.
module cgs_phase_logic import cgs_pkg::*; (
    input  t_phase              i_phase,
    input  logic [TIME_W-1:0]   i_deadline_ms,
    input  logic [DELAY_W-1:0]  i_close_delay_ms,
    input  logic [DELAY_W-1:0]  i_white_delay_ms,
    input  t_poll               i_poll,
    output t_phase              o_phase,
    output logic [TIME_W-1:0]   o_deadline_ms,
    output t_result             o_result
);

    logic [TIME_W-1:0] diff;
    logic              passed;
    logic              closed_both;
    logic              open_both;

    // wrap-safe: signed difference strictly positive
    assign diff        = i_poll.now_ms - i_deadline_ms;
    assign passed      = (diff != '0) && !diff[TIME_W-1];
    assign closed_both = (i_poll.barrier_one_status == BST_CLOSED) &&
                         (i_poll.barrier_two_status == BST_CLOSED);
    assign open_both   = (i_poll.barrier_one_status == BST_OPEN) &&
                         (i_poll.barrier_two_status == BST_OPEN);

    always_comb begin
        o_phase       = i_phase;
        o_deadline_ms = i_deadline_ms;
        o_result      = '0;
        unique case (i_phase)
            PH_SETUP: begin
                o_result.test_lamp_cmd  = TEST_STEADY;
                o_result.white_lamp_cmd = LAMP_ON;
                o_phase                 = PH_IDLE;
            end
            PH_IDLE: begin
                if (i_poll.key_event || i_poll.track_command == TRK_CLOSE) begin
                    o_result.white_lamp_cmd = LAMP_FADE;
                    o_result.test_lamp_cmd  = TEST_BLINK;
                    o_phase                 = PH_RED_START;
                end
            end
            PH_RED_START: begin
                if (i_poll.lamps_dark) begin
                    o_result.red_lamp_cmd = LAMP_ON;
                    o_result.bell_cmd     = BELL_RING;
                    o_deadline_ms = i_poll.now_ms + {{(TIME_W-DELAY_W){1'b0}}, i_close_delay_ms};
                    o_phase       = PH_WAIT_CLOSE;
                end
            end
            PH_WAIT_CLOSE: begin
                if (passed) begin
                    o_result.barrier_cmd = BAR_CLOSE;
                    o_phase              = PH_CLOSING;
                end
            end
            PH_CLOSING: begin
                if (closed_both) begin
                    o_result.bell_cmd        = BELL_STOP;
                    o_result.feedback_write  = 1'b1;
                    o_result.feedback_closed = FEEDBACK_CLOSED;
                    o_phase                  = PH_BELL_OFF;
                end
            end
            PH_BELL_OFF: begin
                if (i_poll.bell_stopped) begin
                    o_phase = PH_CLOSED;
                end
            end
            PH_CLOSED: begin
                if (i_poll.key_event || i_poll.track_command == TRK_OPEN) begin
                    o_result.barrier_cmd = BAR_OPEN;
                    o_phase              = PH_OPENING;
                end
            end
            PH_OPENING: begin
                if (open_both) begin
                    o_result.red_lamp_cmd = LAMP_FADE;
                    o_deadline_ms = i_poll.now_ms + {{(TIME_W-DELAY_W){1'b0}}, i_white_delay_ms};
                    o_phase       = PH_WAIT_WHITE;
                end
            end
            PH_WAIT_WHITE: begin
                if (passed && i_poll.lamps_dark) begin
                    o_result.white_lamp_cmd  = LAMP_ON;
                    o_result.feedback_write  = 1'b1;
                    o_result.feedback_closed = FEEDBACK_OPEN;
                    o_result.test_lamp_cmd   = TEST_STEADY;
                    o_phase                  = PH_IDLE;
                end
            end
            default: begin
                o_phase = i_phase;
            end
        endcase
        o_result.phase_now = o_phase;
    end

endmodule

/* sv/cgs_checker.sv */
// Port-level checks for the crossing gate sequencer, bound to the top level.
// Depends on cgs_pkg and crossing_gate_sequencer_assert.svh.
`include "crossing_gate_sequencer_assert.svh"

module cgs_checker import cgs_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_cfg_we,
    input logic [CFG_IDX_W-1:0] i_cfg_index,
    input logic [DELAY_W-1:0]   i_cfg_data,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic [TIME_W-1:0]    i_now_ms,
    input logic                 i_key_event,
    input logic [CMD_W-1:0]     i_track_command,
    input logic                 i_lamps_dark,
    input logic [CMD_W-1:0]     i_barrier_one_status,
    input logic [CMD_W-1:0]     i_barrier_two_status,
    input logic                 i_bell_stopped,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic [CMD_W-1:0]     o_test_lamp_cmd,
    input logic [CMD_W-1:0]     o_white_lamp_cmd,
    input logic [CMD_W-1:0]     o_red_lamp_cmd,
    input logic [CMD_W-1:0]     o_bell_cmd,
    input logic [CMD_W-1:0]     o_barrier_cmd,
    input logic                 o_feedback_write,
    input logic                 o_feedback_closed,
    input logic [PHASE_W-1:0]   o_phase_now
);

    `CGS_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_out_valid && !o_in_stall)

    `CGS_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_phase_now) && $stable(o_barrier_cmd))

    `CGS_ASSERT_SAME(a_fb_value, i_clk, i_rst_n, o_out_valid && !o_feedback_write,
        !o_feedback_closed)

    `CGS_ASSERT_SAME(a_fb_closed, i_clk, i_rst_n,
        o_out_valid && o_feedback_write && o_feedback_closed,
        o_bell_cmd == BELL_STOP && o_phase_now == PH_BELL_OFF)

    `CGS_ASSERT_SAME(a_close_phase, i_clk, i_rst_n, o_out_valid && o_barrier_cmd == BAR_CLOSE,
        o_phase_now == PH_CLOSING && o_feedback_write == 1'b0)

endmodule

bind crossing_gate_sequencer cgs_checker u_cgs_checker (.*);
